### hw/rtl/mstt_pkg.sv
// Shared types and constants for the multi-slot timeout table.
package mstt_pkg;

  // Fixed field widths of the request and response.
  localparam int SLOT_W    = 4;
  localparam int DUR_W     = 31;
  localparam int FIRED_W   = 16;

  // Request kinds.
  typedef enum logic [1:0] {
    REQ_TICK    = 2'd0,
    REQ_SET     = 2'd1,
    REQ_QUERY   = 2'd2,
    REQ_RELEASE = 2'd3
  } req_e;

  // Response status codes.
  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_UNUSED   = 2'd1,
    ST_NO_FREE  = 2'd2,
    ST_ZERO_DUR = 2'd3
  } status_e;

  // One request as it arrives on the input channel.
  typedef struct packed {
    req_e              req_type;
    logic [SLOT_W-1:0] slot;
    logic [DUR_W-1:0]  duration;
  } in_req_t;

  // One response as it leaves on the output channel.
  typedef struct packed {
    status_e            status;
    logic [SLOT_W-1:0]  slot_out;
    logic               passed;
    logic [FIRED_W-1:0] fired_mask;
  } out_rsp_t;

  // Request token that walks down the chain of slot cells.
  typedef struct packed {
    logic               valid;
    req_e               req_type;
    logic [SLOT_W-1:0]  slot;
    logic               done;
    status_e            status;
    logic [SLOT_W-1:0]  slot_out;
    logic               passed;
    logic [FIRED_W-1:0] fired_mask;
  } tok_t;

endpackage

### hw/rtl/multi_slot_timeout_table_unit.sv
// Top level of the multi-slot timeout table: request entry, chain of slot cells, response register.
// Each request enters an entry register and then walks down a row of SLOTS slot cells, one
// cell per cycle; every cell checks or updates its own slot as the request passes. One request
// is in flight at a time, and the next request is taken once the previous one has reached
// the response register. A stalled response holds the finished request in the last cell and
// delays the next request by the length of the stall. A tick advances the time counter by
// one and reports in fired_mask the slots whose deadline was reached; a set claims the
// lowest free slot; query and release report a slot.
module multi_slot_timeout_table_unit import mstt_pkg::*; #(
  parameter int SLOTS     = 16,
  parameter int TIME_BITS = 32
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_stall_o,
  input  in_req_t  in_req_i,
  output logic     out_valid_o,
  input  logic     out_stall_i,
  output out_rsp_t out_rsp_o
);

  localparam int SumW = (TIME_BITS > DUR_W) ? TIME_BITS : DUR_W;

  logic                 busy_q;
  logic [TIME_BITS-1:0] now_q;
  tok_t                 entry_tok_q;
  logic [TIME_BITS-1:0] entry_time_q;
  tok_t                 entry_tok_d;
  logic [TIME_BITS-1:0] entry_time_d;
  logic [TIME_BITS-1:0] now_inc;
  logic [SumW-1:0]      dur_w;
  logic [TIME_BITS-1:0] set_deadline;
  logic                 in_acc;
  logic                 adv;
  logic                 out_valid_q;
  out_rsp_t             out_rsp_q;
  tok_t                 chain_tok  [SLOTS+1];
  logic [TIME_BITS-1:0] chain_time [SLOTS+1];
  logic [SLOTS-1:0]     cell_valid;
  tok_t                 last_tok;

  assign in_acc       = in_valid_i && !busy_q;
  assign in_stall_o   = busy_q;
  assign last_tok     = chain_tok[SLOTS];
  assign adv          = !(last_tok.valid && out_valid_q && out_stall_i);
  assign now_inc      = now_q + TIME_BITS'(1);
  assign dur_w        = SumW'(in_req_i.duration);
  assign set_deadline = now_q + dur_w[TIME_BITS-1:0];

  // Build the request token with its initial response.
  always_comb begin
    entry_tok_d            = '0;
    entry_tok_d.valid      = 1'b1;
    entry_tok_d.req_type   = in_req_i.req_type;
    entry_tok_d.slot       = in_req_i.slot;
    entry_tok_d.status     = ST_OK;
    entry_time_d           = now_q;
    unique case (in_req_i.req_type)
      REQ_TICK: begin
        entry_time_d = now_inc;
      end
      REQ_SET: begin
        entry_time_d = set_deadline;
        if (in_req_i.duration == '0) begin
          entry_tok_d.status = ST_ZERO_DUR;
          entry_tok_d.done   = 1'b1;
        end else begin
          entry_tok_d.status = ST_NO_FREE;
        end
      end
      REQ_QUERY, REQ_RELEASE: begin
        entry_tok_d.status   = ST_UNUSED;
        entry_tok_d.slot_out = in_req_i.slot;
      end
      default: begin
        entry_time_d = now_q;
      end
    endcase
  end

  // Time counter, busy flag and entry register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      now_q       <= '0;
      busy_q      <= 1'b0;
      entry_tok_q <= '0;
    end else begin
      if (in_acc) begin
        busy_q      <= 1'b1;
        entry_tok_q <= entry_tok_d;
        if (in_req_i.req_type == REQ_TICK) begin
          now_q <= now_inc;
        end
      end else begin
        if (adv) begin
          entry_tok_q.valid <= 1'b0;
        end
        if (last_tok.valid && adv) begin
          busy_q <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      entry_time_q <= entry_time_d;
    end
  end

  assign chain_tok[0]  = entry_tok_q;
  assign chain_time[0] = entry_time_q;

  // Row of slot cells.
  for (genvar g = 0; g < SLOTS; g++) begin : g_cell
    mstt_cell #(
      .TIME_BITS(TIME_BITS),
      .IDX      (g)
    ) u_cell (
      .clk_i (clk_i),
      .rst_ni(rst_ni),
      .adv_i (adv),
      .tok_i (chain_tok[g]),
      .time_i(chain_time[g]),
      .tok_o (chain_tok[g+1]),
      .time_o(chain_time[g+1])
    );
    assign cell_valid[g] = chain_tok[g+1].valid;
  end

  // Response register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (last_tok.valid && adv) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (last_tok.valid && adv) begin
      out_rsp_q.status     <= last_tok.status;
      out_rsp_q.slot_out   <= last_tok.slot_out;
      out_rsp_q.passed     <= last_tok.passed;
      out_rsp_q.fired_mask <= last_tok.fired_mask;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = out_rsp_q;

`ifndef SYNTH
  // At most one request token lives in the chain.
  a_one_token: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $countones({cell_valid, entry_tok_q.valid}) <= 1)
    else $error("more than one request in the cell chain");

  // An idle block has no token in the chain.
  a_idle_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !busy_q |-> (cell_valid == '0) && !entry_tok_q.valid)
    else $error("request token present while idle");

  // A new response comes only from a token leaving the last cell.
  a_rsp_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(last_tok.valid))
    else $error("response without a finished request");
`endif

endmodule

### hw/rtl/mstt_cell.sv
// One timeout slot: holds the slot flags and deadline and serves the passing request token.
module mstt_cell import mstt_pkg::*; #(
  parameter int TIME_BITS = 32,
  parameter int IDX       = 0
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 adv_i,
  input  tok_t                 tok_i,
  input  logic [TIME_BITS-1:0] time_i,
  output tok_t                 tok_o,
  output logic [TIME_BITS-1:0] time_o
);

  localparam logic [SLOT_W-1:0] IdxSlot = SLOT_W'(IDX % (2 ** SLOT_W));
  localparam bit Addressable = (IDX < (2 ** SLOT_W));

  logic                 used_q, used_d;
  logic                 armed_q, armed_d;
  logic                 passed_q, passed_d;
  logic [TIME_BITS-1:0] deadline_q, deadline_d;
  tok_t                 tok_q, tok_d;
  logic [TIME_BITS-1:0] time_q;
  logic [TIME_BITS-1:0] diff;
  logic                 reached;
  logic                 hit;

  // Wraparound deadline compare against the time the token carries.
  assign diff    = deadline_q - time_i;
  assign reached = (diff == '0) || diff[TIME_BITS-1];
  assign hit     = Addressable && (tok_i.slot == IdxSlot);

  // Serve the request token while it moves into this cell.
  always_comb begin
    tok_d      = tok_i;
    used_d     = used_q;
    armed_d    = armed_q;
    passed_d   = passed_q;
    deadline_d = deadline_q;
    if (adv_i && tok_i.valid) begin
      unique case (tok_i.req_type)
        REQ_TICK: begin
          if (used_q && armed_q && !passed_q && reached) begin
            passed_d = 1'b1;
            if (Addressable) begin
              tok_d.fired_mask[IdxSlot] = 1'b1;
            end
          end
        end
        REQ_SET: begin
          if (!tok_i.done && !used_q) begin
            used_d         = 1'b1;
            armed_d        = 1'b1;
            passed_d       = 1'b0;
            deadline_d     = time_i;
            tok_d.done     = 1'b1;
            tok_d.status   = ST_OK;
            tok_d.slot_out = IdxSlot;
          end
        end
        REQ_QUERY, REQ_RELEASE: begin
          if (hit) begin
            if (used_q && armed_q) begin
              tok_d.status = ST_OK;
              tok_d.passed = passed_q;
            end
            if (tok_i.req_type == REQ_RELEASE) begin
              used_d  = 1'b0;
              armed_d = 1'b0;
            end
          end
        end
        default: begin
          tok_d = tok_i;
        end
      endcase
    end
  end

  // Slot flags and token register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      used_q   <= 1'b0;
      armed_q  <= 1'b0;
      passed_q <= 1'b0;
      tok_q    <= '0;
    end else begin
      used_q   <= used_d;
      armed_q  <= armed_d;
      passed_q <= passed_d;
      if (adv_i) begin
        tok_q <= tok_d;
      end
    end
  end

  // Deadline and the carried time need no reset.
  always_ff @(posedge clk_i) begin
    deadline_q <= deadline_d;
    if (adv_i) begin
      time_q <= time_i;
    end
  end

  assign tok_o  = tok_q;
  assign time_o = time_q;

endmodule

### dv/multi_slot_timeout_table_unit_test.sv
// Self-checking testbench for the multi-slot timeout table unit.
module multi_slot_timeout_table_unit_test;
  import mstt_pkg::*;

  localparam int NUM_SLOTS    = 16;
  localparam int TIME_W       = 32;
  localparam int RANDOM_ITEMS = 1525;
  localparam int IDLE_LIMIT   = 3000;
  localparam int TAIL_CYCLES  = 2 * (NUM_SLOTS + 2);

  // One row of the directed sequence; expect_given selects the typed-in reply.
  typedef struct packed {
    req_e       kind;
    logic [3:0] slot;
    logic [30:0] dur;
    logic [4:0] reps;
    logic       expect_given;
    out_rsp_t   reply;
  } timer_step_t;

  localparam out_rsp_t NO_REPLY = '{ST_OK, 4'd0, 1'b0, 16'h0};
  localparam int STEP_COUNT = 26;
  localparam timer_step_t TIMER_STEPS [STEP_COUNT] = '{
    '{REQ_QUERY,   4'd0,  31'd0,          5'd1,  1'b1, '{ST_UNUSED,   4'd0,  1'b0, 16'h0}},
    '{REQ_RELEASE, 4'd15, 31'h7fffffff,   5'd1,  1'b1, '{ST_UNUSED,   4'd15, 1'b0, 16'h0}},
    '{REQ_SET,     4'hA,  31'd0,          5'd1,  1'b1, '{ST_ZERO_DUR, 4'd0,  1'b0, 16'h0}},
    '{REQ_TICK,    4'h5,  31'h55555555,   5'd1,  1'b1, '{ST_OK,       4'd0,  1'b0, 16'h0}},
    '{REQ_SET,     4'hF,  31'd1,          5'd1,  1'b1, '{ST_OK,       4'd0,  1'b0, 16'h0}},
    '{REQ_SET,     4'd0,  31'h7fffffff,   5'd1,  1'b1, '{ST_OK,       4'd1,  1'b0, 16'h0}},
    '{REQ_QUERY,   4'd0,  31'h2aaaaaaa,   5'd1,  1'b1, '{ST_OK,       4'd0,  1'b0, 16'h0}},
    '{REQ_TICK,    4'hA,  31'h2aaaaaaa,   5'd1,  1'b1, '{ST_OK,       4'd0,  1'b0, 16'h1}},
    '{REQ_QUERY,   4'd0,  31'd0,          5'd1,  1'b1, '{ST_OK,       4'd0,  1'b1, 16'h0}},
    // An already passed slot does not fire a second time.
    '{REQ_TICK,    4'd0,  31'd0,          5'd1,  1'b1, '{ST_OK,       4'd0,  1'b0, 16'h0}},
    '{REQ_RELEASE, 4'd0,  31'd0,          5'd1,  1'b1, '{ST_OK,       4'd0,  1'b1, 16'h0}},
    '{REQ_QUERY,   4'd0,  31'd0,          5'd1,  1'b1, '{ST_UNUSED,   4'd0,  1'b0, 16'h0}},
    '{REQ_RELEASE, 4'd0,  31'd0,          5'd1,  1'b1, '{ST_UNUSED,   4'd0,  1'b0, 16'h0}},
    // Fill every free slot, then a set finds the table full.
    '{REQ_SET,     4'd3,  31'd5,          5'd15, 1'b0, NO_REPLY},
    '{REQ_SET,     4'd0,  31'd3,          5'd1,  1'b1, '{ST_NO_FREE,  4'd0,  1'b0, 16'h0}},
    '{REQ_TICK,    4'd0,  31'd0,          5'd5,  1'b0, NO_REPLY},
    '{REQ_QUERY,   4'd15, 31'd0,          5'd1,  1'b1, '{ST_OK,       4'd15, 1'b1, 16'h0}},
    '{REQ_RELEASE, 4'd1,  31'd0,          5'd1,  1'b1, '{ST_OK,       4'd1,  1'b0, 16'h0}},
    '{REQ_QUERY,   4'd1,  31'd0,          5'd1,  1'b1, '{ST_UNUSED,   4'd1,  1'b0, 16'h0}},
    '{REQ_SET,     4'd9,  31'h2aaaaaaa,   5'd1,  1'b0, NO_REPLY},
    '{REQ_SET,     4'd0,  31'd4,          5'd1,  1'b1, '{ST_NO_FREE,  4'd0,  1'b0, 16'h0}},
    // A released slot that had passed is reused with a fresh passed flag.
    '{REQ_RELEASE, 4'd7,  31'd0,          5'd1,  1'b1, '{ST_OK,       4'd7,  1'b1, 16'h0}},
    '{REQ_SET,     4'd0,  31'd2,          5'd1,  1'b1, '{ST_OK,       4'd7,  1'b0, 16'h0}},
    '{REQ_TICK,    4'd0,  31'd0,          5'd1,  1'b0, NO_REPLY},
    '{REQ_TICK,    4'd0,  31'd0,          5'd2,  1'b0, NO_REPLY},
    '{REQ_QUERY,   4'd7,  31'd0,          5'd1,  1'b1, '{ST_OK,       4'd7,  1'b1, 16'h0}}
  };

  logic     clk_i = 1'b0;
  logic     rst_ni = 1'b0;
  logic     in_valid_i = 1'b0;
  logic     in_stall_o;
  in_req_t  in_req_i = '0;
  logic     out_valid_o;
  logic     out_stall_i = 1'b0;
  out_rsp_t out_rsp_o;

  // Shadow copy of the timer table state.
  logic [TIME_W-1:0]    tick_now = '0;
  logic [TIME_W-1:0]    slot_deadline [NUM_SLOTS];
  logic [NUM_SLOTS-1:0] slot_used = '0;
  logic [NUM_SLOTS-1:0] slot_armed = '0;
  logic [NUM_SLOTS-1:0] slot_passed = '0;

  out_rsp_t awaited_replies [$];
  int       fault_count = 0;
  int       idle_cycles = 0;
  int       stall_left = 0;
  int       stall_pct = 0;

  multi_slot_timeout_table_unit #(
    .SLOTS    (NUM_SLOTS),
    .TIME_BITS(TIME_W)
  ) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_req_i   (in_req_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_rsp_o  (out_rsp_o)
  );

  always #10 clk_i = ~clk_i;

  // Applies one request to the shadow table and returns the reply it must produce.
  function automatic out_rsp_t predict_timeout_reply(input in_req_t r);
    out_rsp_t          reply;
    logic [TIME_W-1:0] remaining;
    int                free_slot;
    reply = NO_REPLY;
    free_slot = -1;
    case (r.req_type)
      REQ_TICK: begin
        tick_now = tick_now + 1'b1;
        for (int i = 0; i < NUM_SLOTS; i++) begin
          if (slot_used[i] && slot_armed[i] && !slot_passed[i]) begin
            // Reached when the wrapped distance is zero or negative.
            remaining = slot_deadline[i] - tick_now;
            if (remaining == '0 || remaining[TIME_W-1]) begin
              slot_passed[i] = 1'b1;
              reply.fired_mask[i] = 1'b1;
            end
          end
        end
      end
      REQ_SET: begin
        if (r.duration == '0) begin
          reply.status = ST_ZERO_DUR;
        end else begin
          for (int i = NUM_SLOTS - 1; i >= 0; i--) begin
            if (!slot_used[i]) free_slot = i;
          end
          if (free_slot < 0) begin
            reply.status = ST_NO_FREE;
          end else begin
            slot_used[free_slot] = 1'b1;
            slot_passed[free_slot] = 1'b0;
            slot_deadline[free_slot] = tick_now + TIME_W'(r.duration);
            slot_armed[free_slot] = 1'b1;
            reply.slot_out = free_slot[3:0];
          end
        end
      end
      default: begin
        reply.slot_out = r.slot;
        if (!slot_used[r.slot] || !slot_armed[r.slot]) begin
          reply.status = ST_UNUSED;
        end else begin
          reply.passed = slot_passed[r.slot];
        end
        // Release frees the slot even when it was not in use.
        if (r.req_type == REQ_RELEASE) begin
          slot_used[r.slot] = 1'b0;
          slot_armed[r.slot] = 1'b0;
        end
      end
    endcase
    return reply;
  endfunction

  // Random request; queries and releases are mostly aimed at slots that are in use.
  function automatic in_req_t pick_timer_request();
    in_req_t r;
    int      live_slots [$];
    int      roll;
    r.slot = 4'($urandom());
    r.duration = 31'($urandom());
    roll = $urandom_range(99);
    if (roll < 35) begin
      r.req_type = REQ_TICK;
    end else if (roll < 60) begin
      r.req_type = REQ_SET;
      roll = $urandom_range(99);
      if (roll < 5) begin
        r.duration = '0;
      end else if (roll < 20) begin
        r.duration = 31'($urandom_range(400, 41));
      end else if (roll >= 28) begin
        r.duration = 31'($urandom_range(40, 1));
      end
    end else begin
      r.req_type = (roll < 80) ? REQ_QUERY : REQ_RELEASE;
      for (int i = 0; i < NUM_SLOTS; i++) begin
        if (slot_used[i]) live_slots.push_back(i);
      end
      if (live_slots.size() > 0 && $urandom_range(99) < 85) begin
        r.slot = 4'(live_slots[$urandom_range(live_slots.size() - 1)]);
      end
    end
    return r;
  endfunction

  // Holds the request until it is taken, then records the reply it must give.
  task automatic send_timer_request(input in_req_t r, input logic fixed_reply,
                                    input out_rsp_t given);
    out_rsp_t predicted;
    in_valid_i <= 1'b1;
    in_req_i <= r;
    do @(posedge clk_i); while (in_stall_o);
    predicted = predict_timeout_reply(r);
    awaited_replies.push_back(fixed_reply ? given : predicted);
    @(negedge clk_i);
  endtask

  // Drops valid and waits at a falling edge until every reply is back.
  task automatic drain_replies();
    in_valid_i <= 1'b0;
    while (awaited_replies.size() != 0) @(negedge clk_i);
  endtask

  // Receiver stalls in phases of no, light and heavy back-pressure.
  always @(negedge clk_i) begin
    if (stall_left == 0) begin
      stall_left = $urandom_range(200, 20);
      case ($urandom_range(2))
        0: stall_pct = 0;
        1: stall_pct = 30;
        default: stall_pct = 80;
      endcase
    end
    stall_left--;
    out_stall_i <= ($urandom_range(99) < stall_pct);
  end

  // Compare every accepted reply with the oldest one awaited.
  always @(posedge clk_i) begin
    out_rsp_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (awaited_replies.size() == 0) begin
        $error("reply with none awaited: %h", out_rsp_o);
        fault_count++;
      end else begin
        want = awaited_replies.pop_front();
        if (out_rsp_o.status !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, out_rsp_o.status);
          fault_count++;
        end
        if (out_rsp_o.slot_out !== want.slot_out) begin
          $error("slot_out: expected %0d, got %0d", want.slot_out, out_rsp_o.slot_out);
          fault_count++;
        end
        if (out_rsp_o.passed !== want.passed) begin
          $error("passed: expected %0d, got %0d", want.passed, out_rsp_o.passed);
          fault_count++;
        end
        if (out_rsp_o.fired_mask !== want.fired_mask) begin
          $error("fired_mask: expected %h, got %h", want.fired_mask, out_rsp_o.fired_mask);
          fault_count++;
        end
      end
    end
  end

  // Watchdog on cycles in which neither channel moves.
  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Main sequence: reset, directed steps, random bursts, drain.
  initial begin
    int burst_left;
    int gap;
    for (int i = 0; i < NUM_SLOTS; i++) slot_deadline[i] = '0;
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    foreach (TIMER_STEPS[s]) begin
      for (int k = 0; k < TIMER_STEPS[s].reps; k++) begin
        send_timer_request('{TIMER_STEPS[s].kind, TIMER_STEPS[s].slot, TIMER_STEPS[s].dur},
                           TIMER_STEPS[s].expect_given, TIMER_STEPS[s].reply);
      end
    end
    drain_replies();

    burst_left = $urandom_range(40, 1);
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n == RANDOM_ITEMS / 2) drain_replies();
      send_timer_request(pick_timer_request(), 1'b0, NO_REPLY);
      burst_left--;
      if (burst_left == 0) begin
        burst_left = $urandom_range(40, 1);
        gap = ($urandom_range(3) == 0) ? 0 : $urandom_range(15, 1);
        if (gap > 0) begin
          in_valid_i <= 1'b0;
          repeat (gap) @(negedge clk_i);
        end
      end
    end
    drain_replies();
    repeat (TAIL_CYCLES) @(posedge clk_i);

    if (fault_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

### filelist.f
hw/rtl/mstt_pkg.sv
hw/rtl/mstt_cell.sv
hw/rtl/multi_slot_timeout_table_unit.sv
dv/multi_slot_timeout_table_unit_test.sv
